// ===== design/per_key_event_debouncer_top_assert.svh =====
// assertion macros shared by the debouncer rtl
`ifndef PER_KEY_EVENT_DEBOUNCER_TOP_ASSERT_SVH
`define PER_KEY_EVENT_DEBOUNCER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PKDB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define PKDB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/pkdb_pkg.sv =====
// types, constants and codes of the per-key event debouncer
`timescale 1ns / 1ps
package pkdb_pkg;

   localparam int KEY_COUNT = 256;
   localparam int KEY_BITS  = $clog2(KEY_COUNT);
   localparam int CNT_BITS  = KEY_BITS + 1;
   localparam int TIME_BITS = 32;
   localparam int WIN_BITS  = 14;

   localparam logic [WIN_BITS-1:0] WIN_RESET = 14'd15;

   localparam logic [KEY_BITS-1:0] CODE_VOL_LO = 8'd113;
   localparam logic [KEY_BITS-1:0] CODE_VOL_HI = 8'd115;

   localparam logic       REQ_KEY      = 1'b0;
   localparam logic       REQ_TICK     = 1'b1;
   localparam logic [1:0] VAL_RELEASE  = 2'd0;
   localparam logic [1:0] VAL_PRESS    = 2'd1;
   localparam logic [1:0] VAL_REPEAT   = 2'd2;
   localparam logic [1:0] VAL_RESERVED = 2'd3;

   // one key's stored state
   typedef struct packed {
      logic [TIME_BITS-1:0] wend;
      logic                 wvalid;
      logic                 pending;
      logic                 bounce;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

   // outcome of evaluating one key entry
   typedef struct packed {
      entry_type  entry;
      logic       write;
      logic       flush;
      logic [1:0] n;
      logic [1:0] val0;
      logic [1:0] val1;
   } upd_type;

endpackage

// ===== design/pkdb_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps
module pkdb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== design/pkdb_keyproc.sv =====
// read-modify-write logic for one key entry, for the tick sweep and for key events
`timescale 1ns / 1ps
module pkdb_keyproc (
   input  logic                          sweep,
   input  pkdb_pkg::entry_type           ent,
   input  logic [pkdb_pkg::TIME_BITS-1:0] time_now,
   input  logic [pkdb_pkg::WIN_BITS-1:0]  window_ms,
   input  logic [pkdb_pkg::KEY_BITS-1:0]  code,
   input  logic [1:0]                     value,
   input  logic                           flush_taken,
   output pkdb_pkg::upd_type              upd
);
   import pkdb_pkg::*;

   logic [TIME_BITS-1:0] ahead;
   logic                 inwin;
   logic                 expired;
   logic                 vol;
   logic                 push;
   logic [1:0]           push_val;
   upd_type              o;

   // wrap-aware: end strictly after now, within half the range
   assign ahead   = ent.wend - time_now;
   assign inwin   = ent.wvalid && (ahead != '0) && !ahead[TIME_BITS-1];
   assign expired = ent.pending && !inwin;
   assign vol     = code inside {[CODE_VOL_LO:CODE_VOL_HI]};

   always_comb begin
      o          = '0;
      o.entry    = ent;
      o.val0     = VAL_RELEASE;
      o.val1     = VAL_RELEASE;
      push       = 1'b0;
      push_val   = value;
      if (sweep) begin
         o.write        = 1'b1;
         o.entry.wvalid = ent.wvalid && inwin;
         if (expired && !flush_taken) begin
            o.entry.pending = 1'b0;
            o.entry.bounce  = 1'b0;
            o.flush         = 1'b1;
         end
      end else if (vol) begin
         push = (value != VAL_RESERVED);
      end else begin
         o.write = 1'b1;
         // delayed release that ran out goes first
         if (expired) begin
            o.entry.pending = 1'b0;
            o.entry.bounce  = 1'b0;
            o.n             = 2'd1;
         end
         case (value)
            VAL_PRESS: begin
               if (inwin) begin
                  o.entry.bounce  = 1'b1;
                  o.entry.pending = 1'b0;
               end else begin
                  o.entry.wend   = time_now + TIME_BITS'(window_ms);
                  o.entry.wvalid = 1'b1;
                  o.entry.bounce = 1'b0;
                  push           = 1'b1;
               end
            end
            VAL_RELEASE: begin
               if (inwin) begin
                  if (!o.entry.bounce) begin
                     o.entry.pending = 1'b1;
                  end
               end else begin
                  push = 1'b1;
               end
            end
            VAL_REPEAT: begin
               push = 1'b1;
            end
            default: begin
               push = 1'b0;
            end
         endcase
      end
      if (push) begin
         if (o.n == 2'd0) begin
            o.val0 = push_val;
         end else begin
            o.val1 = push_val;
         end
         o.n = o.n + 2'd1;
      end
   end

   assign upd = o;

endmodule

// ===== design/per_key_event_debouncer_top.sv =====
// top level of the per-key event debouncer: control, key state memory, result register
`timescale 1ns / 1ps
`include "per_key_event_debouncer_top_assert.svh"

// Per-key event debouncer. Requests are key events (req_type 0) or one-millisecond
// ticks (req_type 1); results carry forwarded key events, with rsp_last_of_run set
// on the last result of a request. Key state lives in one 256-entry memory with a
// registered read. A key event reads its entry, then evaluates and writes it back,
// then sends each result it forwards (at most two). A tick walks all 256 entries
// through the memory, one entry per cycle, to age windows and find the lowest key
// whose delayed release has run out, then sends that release if one was found.
// The last result of a request, waiting in the output register, does not hold off
// the next request. The window length may be written at any time the block is
// idle; no clearing pass is needed after reset.
module per_key_event_debouncer_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_type,
   input  logic [pkdb_pkg::KEY_BITS-1:0] req_key_code,
   input  logic [1:0]                    req_key_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [pkdb_pkg::KEY_BITS-1:0] rsp_out_code,
   output logic [1:0]                    rsp_out_value,
   output logic                          rsp_last_of_run,
   input  logic                          csr_wr_en,
   input  logic [pkdb_pkg::WIN_BITS-1:0] csr_debounce_window_ms
);
   import pkdb_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_EVENT = 3'd1;
   localparam logic [2:0] ST_SWEEP = 3'd2;
   localparam logic [2:0] ST_EMIT  = 3'd3;

   logic [2:0]           state_ff,   state_in;
   logic [TIME_BITS-1:0] time_ff,    time_in;
   logic [WIN_BITS-1:0]  win_ff,     win_in;
   logic [KEY_COUNT-1:0] entv_ff,    entv_in;
   logic [CNT_BITS-1:0]  cnt_ff,     cnt_in;
   logic                 pv_ff,      pv_in;
   logic [KEY_BITS-1:0]  paddr_ff,   paddr_in;
   logic                 found_ff,   found_in;
   logic [KEY_BITS-1:0]  cur_code_ff, cur_code_in;
   logic [1:0]           cur_val_ff, cur_val_in;
   logic [KEY_BITS-1:0]  emit_code_ff, emit_code_in;
   logic [1:0]           emit_v0_ff, emit_v0_in;
   logic [1:0]           emit_v1_ff, emit_v1_in;
   logic [1:0]           emit_n_ff,  emit_n_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [KEY_BITS-1:0]  rsp_code_ff, rsp_code_in;
   logic [1:0]           rsp_value_ff, rsp_value_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 req_acc;
   logic                 out_free;
   logic                 rd_en;
   logic [KEY_BITS-1:0]  rd_addr;
   logic [ENTRY_BITS-1:0] rd_data;
   logic                 wr_en;
   logic [KEY_BITS-1:0]  wr_addr;
   logic [KEY_BITS-1:0]  eval_addr;
   entry_type            ent;
   upd_type              upd;
   logic                 sweep;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_acc   = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign sweep     = (state_ff == ST_SWEEP);

   // memory addressing: event lookup on accept, linear walk during a tick
   assign rd_en   = (req_acc && (req_type == REQ_KEY)) || (sweep && !cnt_ff[KEY_BITS]);
   assign rd_addr = sweep ? cnt_ff[KEY_BITS-1:0] : req_key_code;

   assign eval_addr = sweep ? paddr_ff : cur_code_ff;
   // entry never written reads as all flags clear
   assign ent = entv_ff[eval_addr] ? entry_type'(rd_data) : '0;

   assign wr_en   = ((sweep && pv_ff) || (state_ff == ST_EVENT)) && upd.write;
   assign wr_addr = eval_addr;

   pkdb_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (KEY_COUNT)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (upd.entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pkdb_keyproc u_keyproc (
      .sweep       (sweep),
      .ent         (ent),
      .time_now    (time_ff),
      .window_ms   (win_ff),
      .code        (cur_code_ff),
      .value       (cur_val_ff),
      .flush_taken (found_ff),
      .upd         (upd)
   );

   always_comb begin
      state_in     = state_ff;
      time_in      = time_ff;
      win_in       = csr_wr_en ? csr_debounce_window_ms : win_ff;
      entv_in      = entv_ff;
      cnt_in       = cnt_ff;
      pv_in        = 1'b0;
      paddr_in     = cnt_ff[KEY_BITS-1:0];
      found_in     = found_ff;
      cur_code_in  = cur_code_ff;
      cur_val_in   = cur_val_ff;
      emit_code_in = emit_code_ff;
      emit_v0_in   = emit_v0_ff;
      emit_v1_in   = emit_v1_ff;
      emit_n_in    = emit_n_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_code_in  = rsp_code_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;

      if (wr_en) begin
         entv_in[wr_addr] = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_type == REQ_TICK) begin
                  time_in  = time_ff + {{(TIME_BITS-1){1'b0}}, 1'b1};
                  cnt_in   = '0;
                  found_in = 1'b0;
                  state_in = ST_SWEEP;
               end else begin
                  cur_code_in = req_key_code;
                  cur_val_in  = req_key_value;
                  state_in    = ST_EVENT;
               end
            end
         end
         ST_EVENT: begin
            emit_code_in = cur_code_ff;
            emit_v0_in   = upd.val0;
            emit_v1_in   = upd.val1;
            emit_n_in    = upd.n;
            state_in     = (upd.n != 2'd0) ? ST_EMIT : ST_IDLE;
         end
         ST_SWEEP: begin
            if (!cnt_ff[KEY_BITS]) begin
               cnt_in = cnt_ff + 1'b1;
               pv_in  = 1'b1;
            end
            if (pv_ff && upd.flush) begin
               found_in     = 1'b1;
               emit_code_in = paddr_ff;
            end
            // last entry has been written back
            if (cnt_ff[KEY_BITS] && !pv_ff) begin
               if (found_ff) begin
                  emit_v0_in = VAL_RELEASE;
                  emit_n_in  = 2'd1;
                  state_in   = ST_EMIT;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_code_in  = emit_code_ff;
               rsp_value_in = emit_v0_ff;
               rsp_last_in  = (emit_n_ff == 2'd1);
               emit_v0_in   = emit_v1_ff;
               emit_n_in    = emit_n_ff - 2'd1;
               if (emit_n_ff == 2'd1) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         time_ff      <= '0;
         win_ff       <= WIN_RESET;
         entv_ff      <= '0;
         cnt_ff       <= '0;
         pv_ff        <= 1'b0;
         found_ff     <= 1'b0;
         emit_n_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         time_ff      <= time_in;
         win_ff       <= win_in;
         entv_ff      <= entv_in;
         cnt_ff       <= cnt_in;
         pv_ff        <= pv_in;
         found_ff     <= found_in;
         emit_n_ff    <= emit_n_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      paddr_ff     <= paddr_in;
      cur_code_ff  <= cur_code_in;
      cur_val_ff   <= cur_val_in;
      emit_code_ff <= emit_code_in;
      emit_v0_ff   <= emit_v0_in;
      emit_v1_ff   <= emit_v1_in;
      rsp_code_ff  <= rsp_code_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_code    = rsp_code_ff;
   assign rsp_out_value   = rsp_value_ff;
   assign rsp_last_of_run = rsp_last_ff;

   `PKDB_ASSERT_NOW(a_idle_no_backlog, clock, reset, state_ff == ST_IDLE,
      emit_n_ff == 2'd0, "idle with results still queued")
   `PKDB_ASSERT_NOW(a_emit_has_work, clock, reset, state_ff == ST_EMIT,
      emit_n_ff != 2'd0, "emit state with nothing to send")
   `PKDB_ASSERT_NOW(a_no_rw_collision, clock, reset, wr_en && rd_en,
      wr_addr != rd_addr, "read and write of the same key entry in one cycle")
   `PKDB_ASSERT_NOW(a_one_flush_per_tick, clock, reset, sweep && pv_ff && upd.flush,
      !found_ff, "second release flush within one tick")
   `PKDB_ASSERT_NEXT(a_tick_starts_sweep, clock, reset, req_acc && (req_type == REQ_TICK),
      (state_ff == ST_SWEEP) && (cnt_ff == '0) && !found_ff, "tick did not start a sweep")

endmodule

// ===== dv/per_key_event_debouncer_top_tb.sv =====
// self-checking testbench for the per-key event debouncer top level
`timescale 1ns / 1ps
module per_key_event_debouncer_top_tb;
   import pkdb_pkg::*;

   typedef struct {
      logic [KEY_BITS-1:0] code;
      logic [1:0]          value;
      logic                last;
   } fwd_event_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic                req_type;
   logic [KEY_BITS-1:0] req_key_code;
   logic [1:0]          req_key_value;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [KEY_BITS-1:0] rsp_out_code;
   logic [1:0]          rsp_out_value;
   logic                rsp_last_of_run;
   logic                csr_wr_en;
   logic [WIN_BITS-1:0] csr_debounce_window_ms;

   // debouncer state as the testbench sees it
   logic [TIME_BITS-1:0] now_ms;
   logic [WIN_BITS-1:0]  win_len;
   logic [TIME_BITS-1:0] win_end [KEY_COUNT];
   bit                   win_open [KEY_COUNT];
   bit                   rel_held [KEY_COUNT];
   bit                   bounced [KEY_COUNT];

   fwd_event_type fwd_expected_q[$];
   int         fail_count = 0;
   bit         no_gaps = 1'b0;
   int         rsp_hold;

   per_key_event_debouncer_top uut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_type               (req_type),
      .req_key_code           (req_key_code),
      .req_key_value          (req_key_value),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_out_code           (rsp_out_code),
      .rsp_out_value          (rsp_out_value),
      .rsp_last_of_run        (rsp_last_of_run),
      .csr_wr_en              (csr_wr_en),
      .csr_debounce_window_ms (csr_debounce_window_ms)
   );

   always #10 clock = ~clock;

   function automatic bit key_in_window(int k);
      logic [TIME_BITS-1:0] d;
      if (!win_open[k]) return 1'b0;
      d = win_end[k] - now_ms;
      return (d != '0) && !d[TIME_BITS-1];
   endfunction

   function automatic void debounce_predict(logic kind, logic [KEY_BITS-1:0] code,
                                            logic [1:0] val);
      logic [KEY_BITS-1:0] rc [2];
      logic [1:0]          rv [2];
      fwd_event_type       ev;
      int                  n;
      int                  k;
      bit                  hit;
      bit                  inwin;
      n = 0;
      if (kind == REQ_TICK) begin
         now_ms = now_ms + 1'b1;
         for (k = 0; k < KEY_COUNT; k++)
            if (win_open[k] && !key_in_window(k)) win_open[k] = 1'b0;
         // only the lowest expired key is flushed per tick
         hit = 1'b0;
         for (k = 0; k < KEY_COUNT; k++) begin
            if (!hit && rel_held[k] && !key_in_window(k)) begin
               rel_held[k] = 1'b0;
               bounced[k]  = 1'b0;
               rc[0] = KEY_BITS'(k);
               rv[0] = VAL_RELEASE;
               n = 1;
               hit = 1'b1;
            end
         end
      end else if (code >= CODE_VOL_LO && code <= CODE_VOL_HI) begin
         if (val != VAL_RESERVED) begin
            rc[0] = code;
            rv[0] = val;
            n = 1;
         end
      end else begin
         k = int'(code);
         if (rel_held[k] && !key_in_window(k)) begin
            rel_held[k] = 1'b0;
            bounced[k]  = 1'b0;
            rc[n] = code;
            rv[n] = VAL_RELEASE;
            n++;
         end
         inwin = key_in_window(k);
         case (val)
            VAL_PRESS: begin
               if (inwin) begin
                  bounced[k]  = 1'b1;
                  rel_held[k] = 1'b0;
               end else begin
                  win_end[k]  = now_ms + TIME_BITS'(win_len);
                  win_open[k] = 1'b1;
                  bounced[k]  = 1'b0;
                  rc[n] = code;
                  rv[n] = VAL_PRESS;
                  n++;
               end
            end
            VAL_RELEASE: begin
               if (inwin) begin
                  if (!bounced[k]) rel_held[k] = 1'b1;
               end else begin
                  rc[n] = code;
                  rv[n] = VAL_RELEASE;
                  n++;
               end
            end
            VAL_REPEAT: begin
               rc[n] = code;
               rv[n] = VAL_REPEAT;
               n++;
            end
            default: ;
         endcase
      end
      for (int i = 0; i < n; i++) begin
         ev.code  = rc[i];
         ev.value = rv[i];
         ev.last  = (i == n - 1);
         fwd_expected_q.push_back(ev);
      end
   endfunction

   task automatic note_failure(string msg);
      fail_count++;
      if (fail_count <= 10) $display("%s", msg);
   endtask

   task automatic check_response();
      fwd_event_type want;
      if (fwd_expected_q.size() == 0) begin
         note_failure($sformatf("unexpected response: code %0d value %0d last %0b",
                                rsp_out_code, rsp_out_value, rsp_last_of_run));
      end else begin
         want = fwd_expected_q.pop_front();
         if (rsp_out_code !== want.code || rsp_out_value !== want.value ||
             rsp_last_of_run !== want.last)
            note_failure($sformatf(
               "response mismatch: expected code %0d value %0d last %0b, got %0d %0d %0b",
               want.code, want.value, want.last,
               rsp_out_code, rsp_out_value, rsp_last_of_run));
      end
   endtask

   // response side: random stall after each accepted response
   always @(posedge clock) begin : rsp_side
      int stall;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= 0;
      end else if (rsp_hold != 0) begin
         rsp_hold  <= rsp_hold - 1;
         rsp_ready <= (rsp_hold == 1);
      end else if (rsp_valid && rsp_ready) begin
         check_response();
         stall = no_gaps ? 0 : $urandom_range(0, 8);
         rsp_hold  <= stall;
         rsp_ready <= (stall == 0);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_request(logic kind, logic [KEY_BITS-1:0] code, logic [1:0] val);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_type      <= kind;
      req_key_code  <= code;
      req_key_value <= val;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      debounce_predict(kind, code, val);
   endtask

   task automatic send_key(logic [KEY_BITS-1:0] code, logic [1:0] val);
      send_request(REQ_KEY, code, val);
   endtask

   task automatic send_tick();
      send_request(REQ_TICK, KEY_BITS'($urandom_range(0, 255)), 2'($urandom_range(0, 3)));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (fwd_expected_q.size() != 0) @(posedge clock);
   endtask

   // a tick without a flush still walks the whole key memory
   task automatic settle_idle();
      wait_drained();
      repeat (300) @(posedge clock);
   endtask

   task automatic write_window(logic [WIN_BITS-1:0] len);
      settle_idle();
      csr_wr_en              <= 1'b1;
      csr_debounce_window_ms <= len;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      win_len = len;
   endtask

   task automatic test_default_window();
      send_key(8'd0, VAL_PRESS);
      send_key(8'd0, VAL_RELEASE);      // held back inside the window
      send_key(8'd0, VAL_REPEAT);
      send_key(8'd255, VAL_PRESS);
      send_key(CODE_VOL_LO, VAL_PRESS);
      send_key(8'd114, VAL_RELEASE);
      send_key(CODE_VOL_HI, VAL_REPEAT);
      send_key(8'd114, VAL_RESERVED);
      send_key(8'd0, VAL_PRESS);        // bounce cancels the held release
      send_key(8'd0, VAL_RELEASE);      // dropped after bounce
      send_key(8'd255, VAL_RESERVED);
   endtask

   task automatic test_window_extremes();
      write_window(14'd1);
      send_key(8'd10, VAL_PRESS);
      send_key(8'd11, VAL_PRESS);
      send_key(8'd10, VAL_RELEASE);
      send_key(8'd11, VAL_RELEASE);
      send_tick();                      // lowest key flushed first
      send_tick();
      send_key(8'd13, VAL_PRESS);
      send_key(8'd14, VAL_PRESS);
      send_key(8'd13, VAL_RELEASE);
      send_key(8'd14, VAL_RELEASE);
      send_tick();
      send_key(8'd14, VAL_PRESS);       // expired release goes out before the press
      write_window(14'd0);
      send_key(8'd30, VAL_PRESS);
      send_key(8'd30, VAL_RELEASE);
      send_tick();
      write_window(14'd10000);
      send_key(8'd200, VAL_PRESS);
      send_key(8'd200, VAL_RELEASE);
      send_tick();
      send_key(8'd200, VAL_RELEASE);
   endtask

   task automatic send_random_request();
      int                  r;
      logic [KEY_BITS-1:0] code;
      logic [1:0]          val;
      r = $urandom_range(0, 99);
      if (r < 35) begin
         send_tick();
      end else begin
         r = $urandom_range(0, 99);
         if (r < 70)      code = KEY_BITS'($urandom_range(0, 7));
         else if (r < 85) code = KEY_BITS'($urandom_range(113, 115));
         else             code = KEY_BITS'($urandom_range(0, 255));
         r = $urandom_range(0, 99);
         if (r < 40)      val = VAL_PRESS;
         else if (r < 80) val = VAL_RELEASE;
         else if (r < 92) val = VAL_REPEAT;
         else             val = VAL_RESERVED;
         send_key(code, val);
      end
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < 5; phase++) begin
         write_window(WIN_BITS'($urandom_range(1, 6)));
         no_gaps = (phase == 2);
         for (int i = 0; i < 90; i++) begin
            if (i == 45) wait_drained();
            send_random_request();
         end
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      reset                  <= 1'b1;
      req_valid              <= 1'b0;
      req_type               <= REQ_KEY;
      req_key_code           <= '0;
      req_key_value          <= VAL_RELEASE;
      csr_wr_en              <= 1'b0;
      csr_debounce_window_ms <= WIN_RESET;
      now_ms  = '0;
      win_len = WIN_RESET;
      for (int k = 0; k < KEY_COUNT; k++) begin
         win_end[k]  = '0;
         win_open[k] = 1'b0;
         rel_held[k] = 1'b0;
         bounced[k]  = 1'b0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_window();
      test_window_extremes();
      test_random_traffic();
      settle_idle();
      if (fail_count == 0) begin
         $display("per_key_event_debouncer_top_tb: PASS");
      end else begin
         $display("per_key_event_debouncer_top_tb: FAIL");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("per_key_event_debouncer_top_tb: FAIL");
      $finish;
   end

endmodule
